// ===== src/ism_pkg.sv =====
// Shared types and constants for the interval sort and merge block.
// No dependencies; every other file imports this package.
`default_nettype none

package ism_pkg;

    localparam int MAX_RANGES = 64;
    localparam int PAGE_BITS  = 16;
    localparam int IDX_W      = $clog2(MAX_RANGES);
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);

    typedef logic [PAGE_BITS-1:0] page_t;
    typedef logic [PAGE_BITS:0]   page_ext_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    typedef struct packed {
        page_t lo_page;
        page_t hi_page;
        logic  last_item;
    } in_item_t;

    typedef struct packed {
        page_t merged_start;
        page_t merged_end;
        logic  last_range;
        logic  overflow;
    } out_item_t;

    typedef struct packed {
        logic  en;
        idx_t  addr;
        page_t pg_start;
        page_t pg_end;
    } ism_wr_t;

    typedef struct packed {
        logic gt_start;
        logic gt_end;
    } ism_cmp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_MADDR,
        ST_MFIRST,
        ST_MWALK,
        ST_MLAST
    } ism_state_t;

endpackage

`default_nettype wire

// ===== src/interval_sort_merge_top.sv =====
// Top level of the interval sort and merge block: sequencer, output register.
// Depends on ism_pkg, ism_store and ism_cmp.
//
//   channel  signals                        direction  word
//   input    in_valid, in_ready, in_data    in         one page range (in_item_t)
//   output   out_valid, out_ready, out_data out        one merged range (out_item_t)
//
// A range is inserted by a walk that moves each stored range with a larger start up
// one place, one stored entry per cycle through the store's one read and one write
// port; the first range of a set is written directly and a dropped range is not stored.
// The item flagged last then starts a merge walk, one stored entry per cycle,
// held while a merged range waits on a stalled output.
// Reset clears the count, the overflow flag and the output valid, never the store.
`default_nettype none

module interval_sort_merge_top
    import ism_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_item_t in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output out_item_t     out_data
);

    ism_state_t state_reg, state_next;
    cnt_t       count_reg, count_next;
    logic       ovf_reg, ovf_next;
    idx_t       pos_reg, pos_next;
    idx_t       idx_reg, idx_next;
    page_t      s_reg, s_next;
    page_t      e_reg, e_next;
    logic       last_reg, last_next;
    page_t      cur_s_reg, cur_s_next;
    page_t      cur_e_reg, cur_e_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_data_reg, out_data_next;

    ism_wr_t    wr;
    idx_t       rd_addr;
    page_t      rd_start;
    page_t      rd_end;
    page_ext_t  cmp_b;
    ism_cmp_t   cmp;

    logic       fire_in;
    logic       out_free;
    logic       full;
    logic       swap;
    page_t      lo;
    page_t      hi;
    cnt_t       cnt_m1;
    logic       ends_here;
    logic       merge;
    logic       shift;

    ism_store u_store (
        .clk      (clk),
        .wr       (wr),
        .rd_addr  (rd_addr),
        .rd_start (rd_start),
        .rd_end   (rd_end)
    );

    // Insertion compares the stored start with the new start; the merge walk
    // compares it with the running end plus one, formed one bit wider.
    assign cmp_b = (state_reg == ST_INS) ? {1'b0, s_reg}
                                         : ({1'b0, cur_e_reg} + page_ext_t'(1));

    ism_cmp u_cmp (
        .a_start ({1'b0, rd_start}),
        .b_start (cmp_b),
        .a_end   (rd_end),
        .b_end   (cur_e_reg),
        .res     (cmp)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign fire_in   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign full      = (count_reg == cnt_t'(MAX_RANGES));
    assign swap      = in_data.hi_page < in_data.lo_page;
    assign lo        = swap ? in_data.hi_page : in_data.lo_page;
    assign hi        = swap ? in_data.lo_page : in_data.hi_page;
    assign cnt_m1    = count_reg - cnt_t'(1);
    assign ends_here = ((cnt_t'(idx_reg) + cnt_t'(1)) == count_reg);
    assign merge     = !cmp.gt_start;
    assign shift     = (pos_reg != '0) && cmp.gt_start;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (fire_in)
                begin
                    if (full || (count_reg == '0))
                        state_next = in_data.last_item ? ST_MADDR : ST_IDLE;
                    else
                        state_next = ST_INS;
                end
            end
            ST_INS:
            begin
                if (!shift)
                    state_next = last_reg ? ST_MADDR : ST_IDLE;
            end
            ST_MADDR:
                state_next = ST_MFIRST;
            ST_MFIRST:
                state_next = (count_reg == cnt_t'(1)) ? ST_MLAST : ST_MWALK;
            ST_MWALK:
            begin
                if ((merge || out_free) && ends_here)
                    state_next = ST_MLAST;
            end
            ST_MLAST:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        s_next         = s_reg;
        e_next         = e_reg;
        last_next      = last_reg;
        cur_s_next     = cur_s_reg;
        cur_e_next     = cur_e_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        wr.en          = 1'b0;
        wr.addr        = pos_reg;
        wr.pg_start    = s_reg;
        wr.pg_end      = e_reg;
        rd_addr        = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Fetch the top stored entry ahead of the insertion walk.
                rd_addr = cnt_m1[IDX_W-1:0];
                if (fire_in)
                begin
                    s_next    = lo;
                    e_next    = hi;
                    last_next = in_data.last_item;
                    pos_next  = count_reg[IDX_W-1:0];
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else if (count_reg == '0)
                    begin
                        wr.en       = 1'b1;
                        wr.addr     = '0;
                        wr.pg_start = lo;
                        wr.pg_end   = hi;
                        count_next  = cnt_t'(1);
                    end
                end
            end
            ST_INS:
            begin
                if (shift)
                begin
                    // Move the larger entry up one place and fetch the next one down.
                    wr.en       = 1'b1;
                    wr.pg_start = rd_start;
                    wr.pg_end   = rd_end;
                    pos_next    = pos_reg - idx_t'(1);
                    rd_addr     = pos_reg - idx_t'(2);
                end
                else
                begin
                    wr.en      = 1'b1;
                    count_next = count_reg + cnt_t'(1);
                end
            end
            ST_MADDR:
            begin
                rd_addr = '0;
            end
            ST_MFIRST:
            begin
                cur_s_next = rd_start;
                cur_e_next = rd_end;
                idx_next   = idx_t'(1);
                rd_addr    = idx_t'(1);
            end
            ST_MWALK:
            begin
                if (merge)
                begin
                    if (cmp.gt_end)
                        cur_e_next = rd_end;
                    if (!ends_here)
                    begin
                        idx_next = idx_reg + idx_t'(1);
                        rd_addr  = idx_reg + idx_t'(1);
                    end
                end
                else if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.merged_start = cur_s_reg;
                    out_data_next.merged_end   = cur_e_reg;
                    out_data_next.last_range   = 1'b0;
                    out_data_next.overflow     = ovf_reg;
                    cur_s_next                 = rd_start;
                    cur_e_next                 = rd_end;
                    if (!ends_here)
                    begin
                        idx_next = idx_reg + idx_t'(1);
                        rd_addr  = idx_reg + idx_t'(1);
                    end
                end
            end
            ST_MLAST:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.merged_start = cur_s_reg;
                    out_data_next.merged_end   = cur_e_reg;
                    out_data_next.last_range   = 1'b1;
                    out_data_next.overflow     = ovf_reg;
                    count_next                 = '0;
                    ovf_next                   = 1'b0;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        idx_reg      <= idx_next;
        s_reg        <= s_next;
        e_reg        <= e_next;
        last_reg     <= last_next;
        cur_s_reg    <= cur_s_next;
        cur_e_reg    <= cur_e_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

// ===== src/ism_store.sv =====
// Range store: start and end page memories, one write and one registered read port.
// Depends on ism_pkg.
`default_nettype none

module ism_store
    import ism_pkg::*;
(
    input  wire logic    clk,
    input  wire ism_wr_t wr,
    input  wire idx_t    rd_addr,
    output page_t        rd_start,
    output page_t        rd_end
);

    page_t start_mem [MAX_RANGES];
    page_t end_mem   [MAX_RANGES];
    page_t rd_start_reg;
    page_t rd_end_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            start_mem[wr.addr] <= wr.pg_start;
            end_mem[wr.addr]   <= wr.pg_end;
        end
        rd_start_reg <= start_mem[rd_addr];
        rd_end_reg   <= end_mem[rd_addr];
    end

    assign rd_start = rd_start_reg;
    assign rd_end   = rd_end_reg;

endmodule

`default_nettype wire

// ===== src/ism_cmp.sv =====
// Shared compare unit used by both the insertion walk and the merge walk.
// Depends on ism_pkg.
`default_nettype none

module ism_cmp
    import ism_pkg::*;
(
    input  wire page_ext_t a_start,
    input  wire page_ext_t b_start,
    input  wire page_t     a_end,
    input  wire page_t     b_end,
    output ism_cmp_t       res
);

    assign res.gt_start = a_start > b_start;
    assign res.gt_end   = a_end > b_end;

endmodule

`default_nettype wire

// ===== tb/sv/interval_sort_merge_top_test.sv =====
// Self-checking test of interval_sort_merge_top: page range sets are sent, the merged
// ranges are predicted by a sorted store of its own and checked word by word.
// Depends on ism_pkg and the RTL of interval_sort_merge_top.

module interval_sort_merge_top_test;

    import ism_pkg::*;

    localparam int RANDOM_WORDS   = 470;
    localparam int MAX_GAP        = 10;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 150;
    localparam int PAGE_TOP       = (1 << PAGE_BITS) - 1;

    typedef struct {
        in_item_t word;
        int       gap;
        bit       hold;
    } range_slot_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    in_item_t  in_data   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    out_item_t out_data;

    range_slot_t ranges_to_send[$];
    range_slot_t next_slot;
    out_item_t   pending_merges[$];

    // Predictor state: ranges of the open set, sorted by start.
    page_t range_lo_mem[MAX_RANGES];
    page_t range_hi_mem[MAX_RANGES];
    int    stored_ranges = 0;
    bit    ranges_dropped = 1'b0;

    int words_total = 0;
    int words_sent = 0;
    int merges_seen = 0;
    int mismatches = 0;
    int gap_count = 0;
    int stall_count = 0;
    int stall;
    bit rx_quiet = 1'b0;
    int idle_cycles;
    int set_no;
    int directed_words;

    interval_sort_merge_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    task automatic push_merge(input page_t lo, input page_t hi, input bit is_last);
        out_item_t m;
        m.merged_start = lo;
        m.merged_end   = hi;
        m.last_range   = is_last;
        m.overflow     = ranges_dropped;
        pending_merges.push_back(m);
    endtask

    task automatic predict_merges(input in_item_t w);
        page_t lo;
        page_t hi;
        page_t run_lo;
        page_t run_hi;
        int pos;
        lo = w.lo_page;
        hi = w.hi_page;
        if (hi < lo)
        begin
            lo = w.hi_page;
            hi = w.lo_page;
        end
        if (stored_ranges >= MAX_RANGES)
            ranges_dropped = 1'b1;
        else
        begin
            // A new range goes after stored ranges with the same start.
            pos = stored_ranges;
            while (pos > 0 && range_lo_mem[pos-1] > lo)
            begin
                range_lo_mem[pos] = range_lo_mem[pos-1];
                range_hi_mem[pos] = range_hi_mem[pos-1];
                pos--;
            end
            range_lo_mem[pos] = lo;
            range_hi_mem[pos] = hi;
            stored_ranges++;
        end
        if (w.last_item)
        begin
            if (stored_ranges > 0)
            begin
                run_lo = range_lo_mem[0];
                run_hi = range_hi_mem[0];
                for (int i = 1; i < stored_ranges; i++)
                begin
                    // The end is widened by one bit so the top page does not wrap.
                    if (page_ext_t'(run_hi) + 1 >= page_ext_t'(range_lo_mem[i]))
                    begin
                        if (range_hi_mem[i] > run_hi)
                            run_hi = range_hi_mem[i];
                    end
                    else
                    begin
                        push_merge(run_lo, run_hi, 1'b0);
                        run_lo = range_lo_mem[i];
                        run_hi = range_hi_mem[i];
                    end
                end
                push_merge(run_lo, run_hi, 1'b1);
            end
            stored_ranges = 0;
            ranges_dropped = 1'b0;
        end
    endtask

    task automatic check_merge(input out_item_t got);
        out_item_t want;
        if (pending_merges.size() == 0)
        begin
            $error("merged range %0d..%0d arrived with none expected",
                   got.merged_start, got.merged_end);
            mismatches++;
        end
        else
        begin
            want = pending_merges.pop_front();
            if (got.merged_start !== want.merged_start)
            begin
                $error("merged_start: expected %0d, got %0d", want.merged_start, got.merged_start);
                mismatches++;
            end
            if (got.merged_end !== want.merged_end)
            begin
                $error("merged_end: expected %0d, got %0d", want.merged_end, got.merged_end);
                mismatches++;
            end
            if (got.last_range !== want.last_range)
            begin
                $error("last_range: expected %0b, got %0b", want.last_range, got.last_range);
                mismatches++;
            end
            if (got.overflow !== want.overflow)
            begin
                $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
                mismatches++;
            end
        end
    endtask

    task automatic queue_range(input int lo, input int hi, input bit is_last,
                               input int gap, input bit hold);
        range_slot_t slot;
        slot.word.lo_page   = page_t'(lo);
        slot.word.hi_page   = page_t'(hi);
        slot.word.last_item = is_last;
        slot.gap            = gap;
        slot.hold           = hold;
        ranges_to_send.push_back(slot);
    endtask

    function automatic int random_gap();
        return $urandom_range(0, MAX_GAP);
    endfunction

    task automatic add_random_set(input int n_ranges);
        int style;
        int base;
        int lo;
        int hi;
        int t;
        bit quiet;
        bit hold;
        style = $urandom_range(0, 3);
        base  = $urandom_range(0, PAGE_TOP);
        quiet = ($urandom_range(0, 4) == 0);
        hold  = ($urandom_range(0, 5) == 0);
        for (int i = 0; i < n_ranges; i++)
        begin
            case (style)
                0, 1:
                begin
                    // Dense ranges around one base, so most sets merge somewhere.
                    lo = base + $urandom_range(0, 8 * n_ranges + 20);
                    hi = lo + $urandom_range(0, 12);
                end
                2:
                begin
                    lo = $urandom_range(0, PAGE_TOP);
                    hi = $urandom_range(0, PAGE_TOP);
                end
                default:
                begin
                    case ($urandom_range(0, 4))
                        0: lo = 0;
                        1: lo = 1;
                        2: lo = PAGE_TOP - 1;
                        3: lo = PAGE_TOP;
                        default: lo = $urandom_range(0, PAGE_TOP);
                    endcase
                    hi = ($urandom_range(0, 2) == 0) ? PAGE_TOP : lo + $urandom_range(0, 2);
                end
            endcase
            if (lo > PAGE_TOP)
                lo = PAGE_TOP;
            if (hi > PAGE_TOP)
                hi = PAGE_TOP;
            if ($urandom_range(0, 7) == 0)
            begin
                t = lo;
                lo = hi;
                hi = t;
            end
            queue_range(lo, hi, i == n_ranges - 1, quiet ? 0 : random_gap(), hold && i == 0);
        end
    endtask

    // Driver: presents queued range words, with a drawn gap before each one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            in_data   <= '0;
            gap_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_merges(in_data);
                words_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (ranges_to_send.size() == 0)
                    in_valid <= 1'b0;
                else if (ranges_to_send[0].hold && pending_merges.size() != 0)
                    in_valid <= 1'b0;
                else if (gap_count < ranges_to_send[0].gap)
                begin
                    gap_count <= gap_count + 1;
                    in_valid  <= 1'b0;
                end
                else
                begin
                    next_slot = ranges_to_send.pop_front();
                    in_valid  <= 1'b1;
                    in_data   <= next_slot.word;
                    gap_count <= 0;
                end
            end
        end
    end

    // Monitor: checks each merged range and then stalls for a drawn number of cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            stall_count <= 0;
        end
        else if (out_valid && out_ready)
        begin
            check_merge(out_data);
            merges_seen++;
            if (merges_seen % 32 == 0)
                rx_quiet = ($urandom_range(0, 3) == 0);
            stall = rx_quiet ? 0 : random_gap();
            stall_count <= stall;
            out_ready   <= (stall == 0);
        end
        else if (stall_count > 0)
        begin
            stall_count <= stall_count - 1;
            out_ready   <= (stall_count == 1);
        end
        else
            out_ready <= 1'b1;
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        // Single pages at both ends, the whole page space, a reversed range.
        queue_range(0, 0, 1'b1, random_gap(), 1'b0);
        queue_range(PAGE_TOP, PAGE_TOP, 1'b1, random_gap(), 1'b0);
        queue_range(0, PAGE_TOP, 1'b1, random_gap(), 1'b0);
        queue_range(500, 100, 1'b1, random_gap(), 1'b0);
        // Touching, disjoint, overlapping and contained neighbours, out of order.
        queue_range(40, 50, 1'b0, random_gap(), 1'b1);
        queue_range(21, 30, 1'b0, random_gap(), 1'b0);
        queue_range(10, 20, 1'b0, random_gap(), 1'b0);
        queue_range(72, 75, 1'b0, random_gap(), 1'b0);
        queue_range(45, 60, 1'b0, random_gap(), 1'b0);
        queue_range(70, 80, 1'b0, random_gap(), 1'b0);
        queue_range(70, 71, 1'b1, random_gap(), 1'b0);
        // A wide range that swallows later, non-adjacent ones.
        queue_range(0, 100, 1'b0, random_gap(), 1'b0);
        queue_range(30, 40, 1'b0, random_gap(), 1'b0);
        queue_range(10, 20, 1'b0, random_gap(), 1'b0);
        queue_range(200, 300, 1'b1, random_gap(), 1'b0);
        // The top page touches a range that ends just below it.
        queue_range(PAGE_TOP, PAGE_TOP, 1'b0, random_gap(), 1'b1);
        queue_range(PAGE_TOP - 1, 0, 1'b1, random_gap(), 1'b0);
        // Equal starts.
        queue_range(5, 9, 1'b0, 0, 1'b0);
        queue_range(5, 5, 1'b0, 0, 1'b0);
        queue_range(9, 5, 1'b1, 0, 1'b0);
        directed_words = ranges_to_send.size();

        // Two sets fill the store: one exactly, one past it so the words beyond it are dropped.
        set_no = 0;
        while (ranges_to_send.size() < directed_words + RANDOM_WORDS)
        begin
            set_no++;
            if (set_no == 6)
                add_random_set(MAX_RANGES);
            else if (set_no == 20)
                add_random_set(MAX_RANGES + 1 + $urandom_range(0, 4));
            else if ($urandom_range(0, 5) == 0)
                add_random_set($urandom_range(9, 20));
            else
                add_random_set($urandom_range(1, 8));
        end
        words_total = ranges_to_send.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (words_sent != words_total)
            @(posedge clk);
        while (pending_merges.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
